// ----- hdl/ajb_pkg.sv -----
// Package for the audio jitter buffer: constants, status codes,
// configuration register indexes and controller/datapath structs.
// No dependencies.
package ajb_pkg;

  localparam int RING_DEPTH_DEF = 4096;
  localparam int CHUNK_LEN_DEF  = 64;

  localparam int SMP_W  = 16;
  localparam int IN_W   = 17;
  localparam int CFG_W  = 13;
  localparam int FILL_W = 13;

  localparam logic signed [IN_W-1:0] SAMPLE_MAX = 17'sd32767;
  localparam logic signed [IN_W-1:0] SAMPLE_MIN = -17'sd32767;

  localparam logic [CFG_W-1:0] MAX_FILL_RST    = 13'd4096;
  localparam logic [CFG_W-1:0] PRIME_LEVEL_RST = 13'd1024;

  typedef enum logic [1:0] {
    STS_VALID = 2'd0,
    STS_WAIT  = 2'd1,
    STS_UNDER = 2'd2
  } status_t;

  typedef enum logic {
    CFG_MAX_FILL    = 1'b0,
    CFG_PRIME_LEVEL = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic push;
    logic pull;
    logic emit_stat;
    logic stream_en;
  } ajb_cmd_t;

  typedef struct packed {
    status_t kind;
    logic    out_free;
    logic    issue_done;
    logic    pipe_empty;
  } ajb_sts_t;

endpackage

// ----- hdl/ajb_in_if.sv -----
// Input channel of the audio jitter buffer: push/pull action and sample.
// Depends on ajb_pkg.
interface ajb_in_if;
  logic                               valid;
  logic                               ready;
  logic                               action;
  logic signed [ajb_pkg::IN_W-1:0]    sample_in;

  modport source (output valid, action, sample_in, input ready);
  modport sink   (input valid, action, sample_in, output ready);
endinterface

// ----- hdl/ajb_out_if.sv -----
// Result channel of the audio jitter buffer: stereo sample, status, last, fill.
// Depends on ajb_pkg.
interface ajb_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [ajb_pkg::SMP_W-1:0]  left_out;
  logic signed [ajb_pkg::SMP_W-1:0]  right_out;
  logic [1:0]                        status;
  logic                              last;
  logic [ajb_pkg::FILL_W-1:0]        fill_level;

  modport source (output valid, left_out, right_out, status, last, fill_level, input ready);
  modport sink   (input valid, left_out, right_out, status, last, fill_level, output ready);
endinterface

// ----- hdl/ajb_ctrl.sv -----
// Controller of the audio jitter buffer: accepts transactions and sequences
// status results and chunk streaming. Depends on ajb_pkg.
module ajb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_action,
  output logic              in_ready,
  input  ajb_pkg::ajb_sts_t sts,
  output ajb_pkg::ajb_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STAT,
    ST_STREAM
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    cmd.push      = 1'b0;
    cmd.pull      = 1'b0;
    cmd.emit_stat = 1'b0;
    cmd.stream_en = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_action) begin
            cmd.pull = 1'b1;
            if (sts.kind == ajb_pkg::STS_VALID) begin
              state_nxt = ST_STREAM;
            end else begin
              state_nxt = ST_STAT;
            end
          end else begin
            cmd.push = 1'b1;
          end
        end
      end
      ST_STAT: begin
        if (sts.out_free) begin
          cmd.emit_stat = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_STREAM: begin
        cmd.stream_en = 1'b1;
        if (sts.issue_done && sts.pipe_empty) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- hdl/ajb_dpath.sv -----
// Datapath of the audio jitter buffer: sample ring memory, indexes, fill count,
// priming flag, configuration registers and output register. Depends on ajb_pkg.
module ajb_dpath #(
  parameter int RING_DEPTH = ajb_pkg::RING_DEPTH_DEF,
  parameter int CHUNK_LEN  = ajb_pkg::CHUNK_LEN_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ajb_pkg::ajb_cmd_t                 cmd,
  output ajb_pkg::ajb_sts_t                 sts,
  input  logic signed [ajb_pkg::IN_W-1:0]   sample_in,
  input  logic                              cfg_we,
  input  logic                              cfg_addr,
  input  logic [ajb_pkg::CFG_W-1:0]         cfg_wdata,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [ajb_pkg::SMP_W-1:0]  out_sample,
  output logic [1:0]                        out_status,
  output logic                              out_last,
  output logic [ajb_pkg::FILL_W-1:0]        out_fill
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int CW = $clog2(RING_DEPTH + 1);
  localparam int WW = ((CW > ajb_pkg::CFG_W) ? CW : ajb_pkg::CFG_W) + 1;
  localparam int RW = $clog2(CHUNK_LEN + 1);

  logic signed [ajb_pkg::SMP_W-1:0] mem [RING_DEPTH];

  logic [ajb_pkg::CFG_W-1:0] max_fill_r;
  logic [ajb_pkg::CFG_W-1:0] prime_level_r;
  logic [AW-1:0]             rd_r;
  logic [AW-1:0]             wr_r;
  logic [CW-1:0]             held_r;
  logic                      primed_r;
  ajb_pkg::status_t          stat_r;
  logic [RW-1:0]             rem_r;
  logic signed [ajb_pkg::SMP_W-1:0] rdata_r;
  logic                      rv_r;
  logic                      rlast_r;
  logic                      ov_r;
  logic signed [ajb_pkg::SMP_W-1:0] osmp_r;
  logic [1:0]                ostat_r;
  logic                      olast_r;
  logic [ajb_pkg::FILL_W-1:0] ofill_r;

  logic [WW-1:0]             held_w;
  logic [WW-1:0]             mf_w;
  logic [WW-1:0]             lim_w;
  logic [WW-1:0]             drop_w;
  logic [WW:0]               sum_w;
  logic                      over;
  logic [AW-1:0]             rd_drop;
  logic [AW-1:0]             rd_inc;
  logic [AW-1:0]             wr_inc;
  logic signed [ajb_pkg::IN_W-1:0] clamp;
  ajb_pkg::status_t          kind;
  logic                      out_free;
  logic                      move;
  logic                      rd_en;

  assign held_w = WW'(held_r);
  assign mf_w   = WW'(max_fill_r);

  always_comb begin
    if (mf_w == '0) begin
      lim_w = WW'(1);
    end else if (mf_w > WW'(RING_DEPTH)) begin
      lim_w = WW'(RING_DEPTH);
    end else begin
      lim_w = mf_w;
    end
  end

  assign over   = (held_w + WW'(1)) > lim_w;
  assign drop_w = held_w + WW'(1) - lim_w;

  always_comb begin
    sum_w = (WW+1)'(rd_r) + (WW+1)'(drop_w);
    if (sum_w >= (WW+1)'(RING_DEPTH)) begin
      sum_w = sum_w - (WW+1)'(RING_DEPTH);
    end
  end

  assign rd_drop = sum_w[AW-1:0];
  assign rd_inc  = (rd_r == AW'(RING_DEPTH - 1)) ? '0 : rd_r + AW'(1);
  assign wr_inc  = (wr_r == AW'(RING_DEPTH - 1)) ? '0 : wr_r + AW'(1);

  always_comb begin
    if (sample_in > ajb_pkg::SAMPLE_MAX) begin
      clamp = ajb_pkg::SAMPLE_MAX;
    end else if (sample_in < ajb_pkg::SAMPLE_MIN) begin
      clamp = ajb_pkg::SAMPLE_MIN;
    end else begin
      clamp = sample_in;
    end
  end

  always_comb begin
    if (!primed_r && (held_w < WW'(prime_level_r))) begin
      kind = ajb_pkg::STS_WAIT;
    end else if (held_w < WW'(CHUNK_LEN)) begin
      kind = ajb_pkg::STS_UNDER;
    end else begin
      kind = ajb_pkg::STS_VALID;
    end
  end

  assign out_free = !ov_r || out_ready;
  assign move     = rv_r && out_free;
  assign rd_en    = cmd.stream_en && (rem_r != '0) && (!rv_r || move);

  assign sts.kind       = kind;
  assign sts.out_free   = out_free;
  assign sts.issue_done = (rem_r == '0);
  assign sts.pipe_empty = !rv_r;

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_r] <= clamp[ajb_pkg::SMP_W-1:0];
    end
    if (rd_en) begin
      rdata_r <= mem[rd_r];
      rlast_r <= (rem_r == RW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_fill_r    <= ajb_pkg::MAX_FILL_RST;
      prime_level_r <= ajb_pkg::PRIME_LEVEL_RST;
    end else if (cfg_we) begin
      case (ajb_pkg::cfg_idx_t'(cfg_addr))
        ajb_pkg::CFG_MAX_FILL:    max_fill_r    <= cfg_wdata;
        ajb_pkg::CFG_PRIME_LEVEL: prime_level_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r     <= '0;
      wr_r     <= '0;
      held_r   <= '0;
      primed_r <= 1'b0;
      rem_r    <= '0;
      rv_r     <= 1'b0;
      stat_r   <= ajb_pkg::STS_VALID;
    end else begin
      if (cmd.push) begin
        wr_r <= wr_inc;
        if (over) begin
          rd_r   <= rd_drop;
          held_r <= lim_w[CW-1:0];
        end else begin
          held_r <= held_r + CW'(1);
        end
      end else if (rd_en) begin
        rd_r <= rd_inc;
      end
      if (cmd.pull) begin
        stat_r <= kind;
        case (kind)
          ajb_pkg::STS_UNDER: begin
            primed_r <= 1'b0;
          end
          ajb_pkg::STS_VALID: begin
            primed_r <= 1'b1;
            held_r   <= held_r - CW'(CHUNK_LEN);
            rem_r    <= RW'(CHUNK_LEN);
          end
          default: ;
        endcase
      end else if (rd_en) begin
        rem_r <= rem_r - RW'(1);
      end
      if (rd_en) begin
        rv_r <= 1'b1;
      end else if (move) begin
        rv_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (move || cmd.emit_stat) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      osmp_r  <= rdata_r;
      ostat_r <= ajb_pkg::STS_VALID;
      olast_r <= rlast_r;
      ofill_r <= ajb_pkg::FILL_W'(held_r);
    end else if (cmd.emit_stat) begin
      osmp_r  <= '0;
      ostat_r <= stat_r;
      olast_r <= 1'b1;
      ofill_r <= ajb_pkg::FILL_W'(held_r);
    end
  end

  assign out_valid  = ov_r;
  assign out_sample = osmp_r;
  assign out_status = ostat_r;
  assign out_last   = olast_r;
  assign out_fill   = ofill_r;

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CW'(RING_DEPTH))
    else $error("fill count above ring depth");

  a_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.emit_stat && rv_r))
    else $error("status result would overtake chunk data");

  a_hold_rdata: assert property (@(posedge clk) disable iff (!rst_n)
    rv_r && ov_r && !out_ready |=> rv_r && $stable(rdata_r))
    else $error("read data lost under stall");

  a_chunk_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pull && kind == ajb_pkg::STS_VALID |=> rem_r == RW'(CHUNK_LEN) && primed_r)
    else $error("chunk counter not loaded");

endmodule

// ----- hdl/audio_jitter_buffer_core.sv -----
// Audio jitter buffer top level: controller plus datapath; depends on ajb_pkg and interfaces.
// Push: accepted back to back; no result.
// Pull: a waiting/underrun result goes through the status register to the output register;
// a chunk's results stream from the ring read port, one per cycle unless out_ready stalls.
// Next transaction taken only after the last result has entered the output register.
// Reset (synchronous, rst_n low): clears indexes, fill, primed; config to defaults; ring not cleared.
module audio_jitter_buffer_core #(
  parameter int RING_DEPTH = ajb_pkg::RING_DEPTH_DEF,
  parameter int CHUNK_LEN  = ajb_pkg::CHUNK_LEN_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  ajb_in_if.sink                    in_chan,
  ajb_out_if.source                 out_chan,
  input  logic                      cfg_we,
  input  logic                      cfg_addr,
  input  logic [ajb_pkg::CFG_W-1:0] cfg_wdata
);

  ajb_pkg::ajb_cmd_t cmd;
  ajb_pkg::ajb_sts_t sts;
  logic signed [ajb_pkg::SMP_W-1:0] smp;

  ajb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_action (in_chan.action),
    .in_ready  (in_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ajb_dpath #(
    .RING_DEPTH (RING_DEPTH),
    .CHUNK_LEN  (CHUNK_LEN)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .sample_in  (in_chan.sample_in),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .out_sample (smp),
    .out_status (out_chan.status),
    .out_last   (out_chan.last),
    .out_fill   (out_chan.fill_level)
  );

  assign out_chan.left_out  = smp;
  assign out_chan.right_out = smp;

endmodule

// ----- bench/ajb_tb_pkg.sv -----
// Bench-side codes for the audio jitter buffer testbench: the action field encoding.
// Shared by the checker and the testbench top. No dependencies.
`timescale 1ns / 1ps
package ajb_tb_pkg;

  typedef enum logic {
    ACT_PUSH = 1'b0,
    ACT_PULL = 1'b1
  } action_t;

endpackage

// ----- bench/ajb_chunk_checker.sv -----
// Checker for the audio jitter buffer: mirrors the ring, fill and priming state,
// predicts the stereo results of every pull, and compares each result transaction.
// Depends on ajb_pkg, ajb_tb_pkg, ajb_in_if and ajb_out_if.
`timescale 1ns / 1ps
module ajb_chunk_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  ajb_in_if                         in_mon,
  ajb_out_if                        out_mon,
  input  logic                      cfg_we,
  input  logic                      cfg_addr,
  input  logic [ajb_pkg::CFG_W-1:0] cfg_wdata,
  output int                        pending,
  output int                        err_count
);

  localparam int RING  = ajb_pkg::RING_DEPTH_DEF;
  localparam int CHUNK = ajb_pkg::CHUNK_LEN_DEF;

  typedef struct {
    logic signed [ajb_pkg::SMP_W-1:0] left;
    logic signed [ajb_pkg::SMP_W-1:0] right;
    ajb_pkg::status_t                 status;
    logic                             last;
    logic [ajb_pkg::FILL_W-1:0]       fill;
  } stereo_result_t;

  stereo_result_t                   stereo_q[$];
  logic signed [ajb_pkg::SMP_W-1:0] ring_mem [RING];
  int                               rd_pos;
  int                               wr_pos;
  int                               held;
  bit                               primed_r;
  int                               max_fill_r;
  int                               prime_level_r;

  task automatic report_mismatch(string what, int want, int got);
    $display("MISMATCH %s: expected %0d, got %0d", what, want, got);
    err_count++;
  endtask

  task automatic queue_result(logic signed [ajb_pkg::SMP_W-1:0] smp,
                              ajb_pkg::status_t sts, logic lst);
    stereo_result_t r;
    r.left   = smp;
    r.right  = smp;
    r.status = sts;
    r.last   = lst;
    r.fill   = ajb_pkg::FILL_W'(held);
    stereo_q.push_back(r);
  endtask

  task automatic store_sample(logic signed [ajb_pkg::IN_W-1:0] raw);
    logic signed [ajb_pkg::IN_W-1:0] s;
    int                              lim;
    int                              drop;
    s = raw;
    if (s > ajb_pkg::SAMPLE_MAX) s = ajb_pkg::SAMPLE_MAX;
    if (s < ajb_pkg::SAMPLE_MIN) s = ajb_pkg::SAMPLE_MIN;
    lim = max_fill_r;
    if (lim == 0) lim = 1;
    if (lim > RING) lim = RING;
    if (held + 1 > lim) begin
      drop   = held + 1 - lim;
      rd_pos = (rd_pos + drop) % RING;
      held   = held - drop;
    end
    ring_mem[wr_pos] = s[ajb_pkg::SMP_W-1:0];
    wr_pos = (wr_pos + 1) % RING;
    held++;
  endtask

  task automatic drain_chunk();
    logic signed [ajb_pkg::SMP_W-1:0] chunk [CHUNK];
    if (!primed_r) begin
      if (held < prime_level_r) begin
        queue_result('0, ajb_pkg::STS_WAIT, 1'b1);
        return;
      end
      primed_r = 1'b1;
    end
    if (held < CHUNK) begin
      primed_r = 1'b0;
      queue_result('0, ajb_pkg::STS_UNDER, 1'b1);
      return;
    end
    for (int k = 0; k < CHUNK; k++) begin
      chunk[k] = ring_mem[rd_pos];
      rd_pos = (rd_pos + 1) % RING;
    end
    held = held - CHUNK;
    for (int k = 0; k < CHUNK; k++) begin
      queue_result(chunk[k], ajb_pkg::STS_VALID, (k == CHUNK - 1));
    end
  endtask

  task automatic check_result();
    stereo_result_t r;
    if (stereo_q.size() == 0) begin
      report_mismatch("unexpected result, fill", 0, int'(out_mon.fill_level));
      return;
    end
    r = stereo_q.pop_front();
    if (out_mon.left_out !== r.left)
      report_mismatch("left_out", int'(r.left), int'(out_mon.left_out));
    if (out_mon.right_out !== r.right)
      report_mismatch("right_out", int'(r.right), int'(out_mon.right_out));
    if (out_mon.status !== r.status)
      report_mismatch("status", int'(r.status), int'(out_mon.status));
    if (out_mon.last !== r.last)
      report_mismatch("last", int'(r.last), int'(out_mon.last));
    if (out_mon.fill_level !== r.fill)
      report_mismatch("fill_level", int'(r.fill), int'(out_mon.fill_level));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      stereo_q.delete();
      rd_pos        = 0;
      wr_pos        = 0;
      held          = 0;
      primed_r      = 1'b0;
      max_fill_r    = int'(ajb_pkg::MAX_FILL_RST);
      prime_level_r = int'(ajb_pkg::PRIME_LEVEL_RST);
      err_count     = 0;
      foreach (ring_mem[i]) ring_mem[i] = '0;
    end else begin
      if (cfg_we) begin
        if (ajb_pkg::cfg_idx_t'(cfg_addr) == ajb_pkg::CFG_MAX_FILL)
          max_fill_r = int'(cfg_wdata);
        else prime_level_r = int'(cfg_wdata);
      end
      if (out_mon.valid && out_mon.ready) check_result();
      if (in_mon.valid && in_mon.ready) begin
        if (ajb_tb_pkg::action_t'(in_mon.action) == ajb_tb_pkg::ACT_PULL) drain_chunk();
        else store_sample(in_mon.sample_in);
      end
    end
    pending <= stereo_q.size();
  end

endmodule

// ----- bench/tb_audio_jitter_buffer_core.sv -----
// Testbench top for audio_jitter_buffer_core: clock, reset, push/pull stimulus,
// configuration writes, result back-pressure and the verdict.
// Depends on ajb_pkg, ajb_tb_pkg, the channel interfaces and ajb_chunk_checker.
`timescale 1ns / 1ps
module tb_audio_jitter_buffer_core;

  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_GAP   = 8;
  localparam int TAIL_GAP    = 20;
  localparam int LONG_HOLD   = 400;
  localparam int DEEP_PUSHES = 70;
  localparam int DEEP_LIMIT  = 64;
  localparam int PHASE_ITEMS = 20;
  localparam int N_PHASES    = 9;
  localparam int PH_FILL  [N_PHASES] = '{4096, 64, 100, 1, 130, 200, 70, 8191, 4096};
  localparam int PH_PRIME [N_PHASES] = '{64, 64, 0, 0, 8191, 130, 4096, 1, 4096};

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      cfg_we;
  logic                      cfg_addr;
  logic [ajb_pkg::CFG_W-1:0] cfg_wdata;
  int                        n_pending;
  int                        n_errors;
  int                        stall_cycles = 0;
  bit                        gaps_on = 1'b1;
  bit                        hold_rx = 1'b0;

  ajb_in_if  in_chan ();
  ajb_out_if out_chan ();

  audio_jitter_buffer_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  ajb_chunk_checker u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_chan),
    .out_mon   (out_chan),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .pending   (n_pending),
    .err_count (n_errors)
  );

  always #2 clk = ~clk;

  function automatic logic signed [ajb_pkg::IN_W-1:0] rand_sample();
    int v;
    if ($urandom_range(0, 9) < 7) begin
      v = int'($urandom_range(0, 65534)) - 32767;
      return v[ajb_pkg::IN_W-1:0];
    end
    return ajb_pkg::IN_W'($urandom());
  endfunction

  task automatic send_item(ajb_tb_pkg::action_t act, logic signed [ajb_pkg::IN_W-1:0] smp);
    int gap;
    gap = gaps_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.action    <= act;
    in_chan.sample_in <= smp;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  task automatic write_reg(ajb_pkg::cfg_idx_t idx, int val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= ajb_pkg::CFG_W'(val);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic wait_drained(int gap);
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (gap) @(posedge clk);
  endtask

  task automatic run_phase(int n_items);
    int left;
    int burst;
    left = n_items;
    while (left > 0) begin
      if ($urandom_range(0, 4) == 0) begin
        send_item(ajb_tb_pkg::action_t'($urandom_range(0, 1)), ajb_pkg::IN_W'($urandom()));
        left--;
      end else begin
        burst = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : $urandom_range(60, 72);
        while (burst > 0 && left > 0) begin
          send_item(ajb_tb_pkg::ACT_PUSH, rand_sample());
          burst--;
          left--;
        end
        if (left > 0) begin
          send_item(ajb_tb_pkg::ACT_PULL, rand_sample());
          left--;
        end
      end
    end
  endtask

  initial begin
    rst_n             <= 1'b0;
    in_chan.valid     <= 1'b0;
    in_chan.action    <= ajb_tb_pkg::ACT_PUSH;
    in_chan.sample_in <= '0;
    cfg_we            <= 1'b0;
    cfg_addr          <= ajb_pkg::CFG_MAX_FILL;
    cfg_wdata         <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_item(ajb_tb_pkg::ACT_PULL, '0);
    send_item(ajb_tb_pkg::ACT_PUSH, 17'sd65535);
    send_item(ajb_tb_pkg::ACT_PUSH, -17'sd65536);
    send_item(ajb_tb_pkg::ACT_PUSH, 17'sd32767);
    send_item(ajb_tb_pkg::ACT_PUSH, -17'sd32767);
    send_item(ajb_tb_pkg::ACT_PUSH, 17'sd32768);
    send_item(ajb_tb_pkg::ACT_PUSH, -17'sd32768);
    send_item(ajb_tb_pkg::ACT_PUSH, 17'sd0);
    send_item(ajb_tb_pkg::ACT_PUSH, -17'sd1);
    send_item(ajb_tb_pkg::ACT_PUSH, 17'sd1);
    send_item(ajb_tb_pkg::ACT_PULL, '1);
    wait_drained(DRAIN_GAP);

    write_reg(ajb_pkg::CFG_MAX_FILL, 0);
    write_reg(ajb_pkg::CFG_PRIME_LEVEL, 0);
    send_item(ajb_tb_pkg::ACT_PUSH, 17'sd100);
    send_item(ajb_tb_pkg::ACT_PUSH, -17'sd200);
    send_item(ajb_tb_pkg::ACT_PUSH, 17'sd300);
    send_item(ajb_tb_pkg::ACT_PULL, '0);
    send_item(ajb_tb_pkg::ACT_PULL, '0);
    send_item(ajb_tb_pkg::ACT_PUSH, 17'sd5);
    wait_drained(DRAIN_GAP);

    write_reg(ajb_pkg::CFG_MAX_FILL, 8191);
    write_reg(ajb_pkg::CFG_PRIME_LEVEL, 8191);
    send_item(ajb_tb_pkg::ACT_PULL, '0);
    send_item(ajb_tb_pkg::ACT_PUSH, 17'sd7);
    send_item(ajb_tb_pkg::ACT_PULL, '0);
    wait_drained(DRAIN_GAP);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      gaps_on = (ph % 3 != 2);
      write_reg(ajb_pkg::CFG_MAX_FILL, PH_FILL[ph]);
      write_reg(ajb_pkg::CFG_PRIME_LEVEL, PH_PRIME[ph]);
      run_phase(PHASE_ITEMS);
      wait_drained(DRAIN_GAP);

      if (ph == 1) begin
        // push past the fill limit, then stall the result side
        gaps_on = 1'b0;
        write_reg(ajb_pkg::CFG_MAX_FILL, DEEP_LIMIT);
        write_reg(ajb_pkg::CFG_PRIME_LEVEL, DEEP_LIMIT);
        repeat (DEEP_PUSHES) send_item(ajb_tb_pkg::ACT_PUSH, rand_sample());
        hold_rx = 1'b1;
        repeat (4) send_item(ajb_tb_pkg::ACT_PULL, '0);
        wait_drained(DRAIN_GAP);
      end
    end

    wait_drained(TAIL_GAP);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    int gap;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_rx) begin
        gap = LONG_HOLD;
        hold_rx = 1'b0;
      end else begin
        gap = gaps_on ? $urandom_range(0, 9) : 0;
      end
      if (gap > 0) begin
        out_chan.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      @(posedge clk);
      while (!out_chan.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

endmodule
